[rtl/core/prf_pkg.sv]
`default_nettype none
package prf_pkg;
    localparam int MOD_BITS    = 16;
    localparam int MAX_FACTORS = 6;
    localparam int FAC_IDX_W   = $clog2(MAX_FACTORS + 1);
    localparam int CNT_W       = $clog2(MOD_BITS + 1);

    // datapath operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_HALVE   = 4'd2;
    localparam logic [3:0] OP_DIV_GO  = 4'd3;
    localparam logic [3:0] OP_DIV_STP = 4'd4;
    localparam logic [3:0] OP_SQ_CHK  = 4'd5;
    localparam logic [3:0] OP_DIVIDE  = 4'd6;
    localparam logic [3:0] OP_NEXT_D  = 4'd7;
    localparam logic [3:0] OP_ADD_FAC = 4'd8;
    localparam logic [3:0] OP_SEL_FAC = 4'd9;
    localparam logic [3:0] OP_POW_STP = 4'd10;
    localparam logic [3:0] OP_NEXT_R  = 4'd11;
    localparam logic [3:0] OP_FAC_M   = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic small_n;    // n below three
        logic m_even;
        logic m_zero;
        logic div_busy;   // shared divider running
        logic div_zero;   // last remainder is zero
        logic sq_gt;      // d*d > m
        logic m_gt2;
        logic pow_busy;
        logic pow_one;    // last power equals one
        logic fac_last;   // selected factor is the last stored
        logic no_fac;
        logic r_last;     // candidate equals n-1
    } t_sts;
endpackage
`default_nettype wire

[rtl/core/prf_ctrl.sv]
`default_nettype none
module prf_ctrl
    import prf_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    output logic o_valid,
    input  wire  i_ready,
    output logic o_found_set,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_EVEN  = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_DIVW  = 4'd4;
    localparam logic [3:0] S_DIVD  = 4'd5;
    localparam logic [3:0] S_LASTF = 4'd6;
    localparam logic [3:0] S_SEL   = 4'd7;
    localparam logic [3:0] S_POW   = 4'd8;
    localparam logic [3:0] S_PCHK  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_EVEN2 = 4'd11;
    localparam logic [3:0] S_POWQ  = 4'd12;
    localparam logic [3:0] S_EXPW  = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_found, n_found;

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_found_set = r_found;

    always_comb begin
        n_state = r_state;
        n_found = r_found;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.op = OP_LOAD; n_found = 1'b0; n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.small_n) n_state = S_OUT;
                else if (i_sts.m_zero) n_state = S_SEL;
                else n_state = S_EVEN;
            end
            S_EVEN: begin
                if (i_sts.m_even) begin
                    o_cmd.op = OP_ADD_FAC; n_state = S_EVEN2;
                end else n_state = S_SQ;
            end
            S_EVEN2: begin o_cmd.op = OP_HALVE; n_state = S_EVEN; end
            S_SQ: begin
                if (i_sts.sq_gt) n_state = S_LASTF;
                else begin o_cmd.op = OP_DIV_GO; n_state = S_DIVW; end
            end
            S_DIVW: begin
                o_cmd.op = OP_DIV_STP;
                if (!i_sts.div_busy) n_state = S_DIVD;
            end
            S_DIVD: begin
                if (i_sts.div_zero) begin o_cmd.op = OP_DIVIDE; n_state = S_SQ; end
                else begin o_cmd.op = OP_NEXT_D; n_state = S_SQ; end
            end
            S_LASTF: begin
                if (i_sts.m_gt2) o_cmd.op = OP_FAC_M;
                n_state = S_SEL;
            end
            S_SEL: begin
                if (i_sts.no_fac) begin n_found = 1'b1; n_state = S_OUT; end
                else begin o_cmd.op = OP_SEL_FAC; n_state = S_POWQ; end
            end
            S_POWQ: begin o_cmd.op = OP_DIV_GO; n_state = S_EXPW; end
            // wait for the exponent, then start powering
            S_EXPW: begin
                if (!i_sts.div_busy) begin o_cmd.op = OP_POW_STP; n_state = S_POW; end
            end
            S_POW: begin
                if (i_sts.pow_busy) o_cmd.op = OP_POW_STP;
                else n_state = S_PCHK;
            end
            S_PCHK: begin
                if (i_sts.pow_one) begin
                    if (i_sts.r_last) n_state = S_OUT;
                    else begin o_cmd.op = OP_NEXT_R; n_state = S_SEL; end
                end else if (i_sts.fac_last) begin
                    n_found = 1'b1; n_state = S_OUT;
                end else begin o_cmd.op = OP_SEL_FAC; n_state = S_POWQ; end
            end
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_valid |=> r_state == S_CHK) else $error("start lost");
endmodule
`default_nettype wire

[rtl/core/prf_dp.sv]
`default_nettype none
module prf_dp
    import prf_pkg::*;
(
    input  wire                 i_clk,
    input  wire  [15:0]         i_modulus,
    input  t_cmd                i_cmd,
    input  wire                 i_found,
    output t_sts                o_sts,
    output logic [15:0]         o_root
);
    localparam int W = MOD_BITS;

    logic [W-1:0]     r_n, r_phi, r_m, r_d, r_r, r_p;
    logic [W-1:0]     r_fac [MAX_FACTORS];
    logic [FAC_IDX_W-1:0] r_cnt, r_sel;
    // shared restoring divider: quotient/remainder of r_dn / r_dd
    logic [W-1:0]     r_dq, r_drem, r_dn, r_dd;
    logic [CNT_W-1:0] r_dc;
    logic             r_dbusy;
    // square-and-multiply
    logic [W-1:0]     r_e, r_acc, r_base;
    logic [2*W-1:0]   r_prod;
    logic [1:0]       r_ph;   // 0 mult acc, 1 reduce acc, 2 square, 3 reduce base
    logic             r_pbusy;
    // modular reducer, bit per cycle over a double-width product
    logic [2*W-1:0]   r_rv;
    logic [W:0]       r_rr;
    logic [$clog2(2*W+1)-1:0] r_rc;
    logic             r_rbusy;

    logic [W:0]   div_try, red_try;
    logic [2*W-1:0] d_sq;
    logic         fac_dup;
    logic [W-1:0] fac_new;

    assign d_sq    = r_d * r_d;
    assign div_try = {r_drem, r_dn[W-1]} - {1'b0, r_dd};
    assign red_try = {r_rr[W-1:0], r_rv[2*W-1]} - {1'b0, r_n};
    assign fac_new = (i_cmd.op == OP_ADD_FAC) ? W'(2) :
                     (i_cmd.op == OP_DIVIDE) ? r_d : r_m;

    always_comb begin
        fac_dup = 1'b0;
        for (int k = 0; k < MAX_FACTORS; k++)
            if (FAC_IDX_W'(k) < r_cnt && r_fac[k] == fac_new) fac_dup = 1'b1;
    end

    always_comb begin
        o_sts.small_n  = (r_n < W'(3));
        o_sts.m_even   = ~r_m[0];
        o_sts.m_zero   = (r_m == '0);
        o_sts.div_busy = r_dbusy;
        o_sts.div_zero = (r_drem == '0);
        o_sts.sq_gt    = (d_sq > {{W{1'b0}}, r_m});
        o_sts.m_gt2    = (r_m > W'(2));
        o_sts.pow_busy = r_pbusy;
        o_sts.pow_one  = (r_acc == W'(1));
        o_sts.fac_last = (r_sel == r_cnt);
        o_sts.no_fac   = (r_cnt == '0);
        o_sts.r_last   = (r_r == r_phi);
    end

    assign o_root = i_found ? 16'(r_r) : 16'd0;

    always_ff @(posedge i_clk) begin
        // reducer advance
        if (r_rbusy) begin
            r_rv <= {r_rv[2*W-2:0], 1'b0};
            r_rr <= red_try[W] ? {r_rr[W-1:0], r_rv[2*W-1]} : red_try;
            r_rc <= r_rc - 1'b1;
            if (r_rc == 1) r_rbusy <= 1'b0;
        end
        // divider advance
        if (r_dbusy) begin
            r_dn <= {r_dn[W-2:0], 1'b0};
            if (div_try[W]) begin
                r_drem <= {r_drem[W-2:0], r_dn[W-1]};
                r_dq   <= {r_dq[W-2:0], 1'b0};
            end else begin
                r_drem <= div_try[W-1:0];
                r_dq   <= {r_dq[W-2:0], 1'b1};
            end
            r_dc <= r_dc - 1'b1;
            if (r_dc == 1) r_dbusy <= 1'b0;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_n   <= i_modulus[W-1:0];
                r_phi <= i_modulus[W-1:0] - 1'b1;
                r_m   <= i_modulus[W-1:0] - 1'b1;
                r_d   <= W'(3);
                r_r   <= W'(2);
                r_cnt <= '0;
                r_sel <= '0;
                r_dbusy <= 1'b0; r_pbusy <= 1'b0; r_rbusy <= 1'b0;
            end
            OP_ADD_FAC, OP_FAC_M: begin
                if (!fac_dup && r_cnt < FAC_IDX_W'(MAX_FACTORS)) begin
                    r_fac[r_cnt[FAC_IDX_W-1:0]] <= fac_new;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            OP_HALVE: r_m <= r_m >> 1;
            OP_DIV_GO: begin
                // exponent (n-1)/p once a factor is selected, else trial division
                r_dn <= (r_sel != '0) ? r_phi : r_m;
                r_dd <= (r_sel != '0) ? r_p : r_d;
                r_drem <= '0; r_dq <= '0;
                r_dc <= CNT_W'(W);
                r_dbusy <= 1'b1;
            end
            OP_DIVIDE: begin
                if (!fac_dup && r_cnt < FAC_IDX_W'(MAX_FACTORS)) begin
                    r_fac[r_cnt[FAC_IDX_W-1:0]] <= r_d;
                    r_cnt <= r_cnt + 1'b1;
                end
                r_m <= r_dq;
            end
            OP_NEXT_D: r_d <= r_d + W'(2);
            OP_SEL_FAC: begin
                r_p   <= r_fac[r_sel[FAC_IDX_W-1:0] < FAC_IDX_W'(MAX_FACTORS)
                               ? r_sel : '0];
                r_sel <= r_sel + 1'b1;
                r_pbusy <= 1'b0;
            end
            OP_POW_STP: begin
                if (!r_dbusy && !r_pbusy) begin
                    // divider done: exponent ready, start powering from base r
                    r_e     <= r_dq;
                    r_acc   <= W'(1);
                    r_rr    <= {1'b0, r_r};
                    r_ph    <= 2'd0;
                    r_pbusy <= (r_dq != '0);
                end else if (r_pbusy && !r_rbusy) begin
                    case (r_ph)
                        2'd0: begin
                            // reduced base sits in the reducer remainder
                            r_prod <= r_e[0] ? r_acc * r_rr[W-1:0]
                                             : {{W{1'b0}}, r_acc};
                            r_base <= r_rr[W-1:0];
                            r_ph <= 2'd1;
                        end
                        2'd1: begin
                            r_rv <= r_prod; r_rr <= '0;
                            r_rc <= ($clog2(2*W+1))'(2*W); r_rbusy <= 1'b1;
                            r_ph <= 2'd2;
                        end
                        2'd2: begin
                            r_acc  <= r_rr[W-1:0];
                            r_prod <= r_base * r_base;
                            r_ph   <= 2'd3;
                        end
                        default: begin
                            // skip the square reduction after the last bit
                            if (r_e == W'(1)) r_pbusy <= 1'b0;
                            else begin
                                r_rv <= r_prod; r_rr <= '0;
                                r_rc <= ($clog2(2*W+1))'(2*W); r_rbusy <= 1'b1;
                            end
                            r_e  <= r_e >> 1;
                            r_ph <= 2'd0;
                        end
                    endcase
                end
            end
            OP_NEXT_R: begin
                r_r <= r_r + 1'b1;
                r_sel <= '0;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[rtl/core/primitive_root_finder.sv]
// Channel | Direction | Signals
// modulus | in        | i_valid, o_ready, i_modulus[15:0]
// result  | out       | o_valid, i_ready, o_root[15:0], o_found
// One word at a time; latency is data dependent: trial division steps
// through the odd divisors and each power through the exponent bits,
// using the bit-serial divider and modular reducer.
// Synchronous active-low reset returns the controller to idle.
// The result is held until taken; no new word is accepted meanwhile.
`default_nettype none
module primitive_root_finder
    import prf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [15:0] i_modulus,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_root,
    output logic        o_found
);
    t_cmd cmd;
    t_sts sts;
    logic found;

    prf_ctrl u_ctrl (.i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_found_set(found), .o_cmd(cmd), .i_sts(sts));
    prf_dp u_dp (.i_clk, .i_modulus, .i_cmd(cmd), .i_found(found),
        .o_sts(sts), .o_root);

    assign o_found = found;
endmodule
`default_nettype wire

[test/primitive_root_finder_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module primitive_root_finder_test
    import prf_pkg::*;
;

    typedef struct packed {
        logic [15:0] root;
        logic        found;
    } t_root_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_modulus;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_root;
    logic        o_found;

    t_root_word  roots_pending[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    primitive_root_finder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_modulus(i_modulus),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_root   (o_root),
        .o_found  (o_found)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        repeat (40) #100_000_000;
        $display("primitive_root_finder_test NOT OK");
        $finish;
    end

    // base^e mod m with exact wide products
    function automatic longint unsigned pow_mod(longint unsigned base,
                                                longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        acc  = 1 % m;
        base = base % m;
        while (e > 0) begin
            if (e[0]) acc = (acc * base) % m;
            e    = e >> 1;
            base = (base * base) % m;
        end
        return acc;
    endfunction

    // Smallest candidate passing the factor test for modulus n
    function automatic t_root_word smallest_root(logic [15:0] word);
        longint unsigned n, phi, m, d, r;
        longint unsigned factors[MAX_FACTORS];
        int              nfac;
        bit              dup, pass;
        t_root_word      res;
        res  = '0;
        nfac = 0;
        n    = longint'(word) & ((64'd1 << MOD_BITS) - 1);
        if (n < 3) return res;
        phi = n - 1;
        m   = phi;
        // collect distinct prime factors of n-1
        for (d = 2; d * d <= m || d == 2; d = (d == 2) ? 3 : d + 2) begin
            while (m % d == 0) begin
                dup = 0;
                for (int k = 0; k < nfac; k++) if (factors[k] == d) dup = 1;
                if (!dup && nfac < MAX_FACTORS) begin
                    factors[nfac] = d;
                    nfac++;
                end
                m = m / d;
            end
        end
        if (m > 2) begin
            dup = 0;
            for (int k = 0; k < nfac; k++) if (factors[k] == m) dup = 1;
            if (!dup && nfac < MAX_FACTORS) begin
                factors[nfac] = m;
                nfac++;
            end
        end
        // scan candidates in order
        for (r = 2; r <= phi; r++) begin
            pass = 1;
            for (int k = 0; k < nfac && pass; k++)
                if (pow_mod(r, phi / factors[k], n) == 1) pass = 0;
            if (pass) begin
                res.root  = r[15:0];
                res.found = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    function automatic bit is_prime(int unsigned v);
        if (v < 2) return 0;
        for (int unsigned d = 2; d * d <= v; d++) if (v % d == 0) return 0;
        return 1;
    endfunction

    // Next prime at or above v, wrapping to three past the top
    function automatic logic [15:0] prime_from(int unsigned v);
        while (!is_prime(v)) begin
            v++;
            if (v > 65535) v = 3;
        end
        return v[15:0];
    endfunction

    // Pick a modulus: mostly primes, some small composites and noise
    function automatic logic [15:0] pick_modulus();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40) return prime_from($urandom_range(1023, 3));
        if (sel < 75) return prime_from($urandom_range(65535, 3));
        if (sel < 82) return prime_from($urandom_range(65535, 60000));
        if (sel < 94) return 16'($urandom_range(64, 4));
        return 16'($urandom_range(2));
    endfunction

    // Offer one word and hold it until taken
    task automatic send_modulus(logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_valid   = 1'b1;
        i_modulus = value;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid   = 1'b0;
        i_modulus = 16'($urandom);
    endtask

    // Predict on every accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) roots_pending.push_back(smallest_root(i_modulus));
    end

    // Check each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_root_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (roots_pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result root=%0d found=%0d", o_root, o_found);
            end else begin
                want = roots_pending.pop_front();
                if (o_root !== want.root || o_found !== want.found) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected root=%0d found=%0d, got root=%0d found=%0d",
                                 want.root, want.found, o_root, o_found);
                end
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_directed();
        logic [15:0] list[$];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        list = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd9,
                 16'd12, 16'd15, 16'd23, 16'd41, 16'd191, 16'd257, 16'd409,
                 16'd32749, 16'd40961, 16'd65521, 16'd65535, 16'd65519,
                 16'd43691, 16'd21845, 16'd16};
        foreach (list[k]) send_modulus(list[k]);
    endtask

    task automatic run_random(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_modulus(pick_modulus());
    endtask

    task automatic test_no_idle();         run_random(30, 0, 0);   endtask
    task automatic test_sender_idle();     run_random(30, 76, 0);  endtask
    task automatic test_receiver_stall();  run_random(30, 0, 76);  endtask
    task automatic test_both_idle();       run_random(30, 27, 27); endtask

    initial begin
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_modulus = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        // Drain outstanding results, then let the block settle
        while (roots_pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("primitive_root_finder_test OK");
        end else begin
            $display("primitive_root_finder_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/core/prf_pkg.sv
rtl/core/prf_ctrl.sv
rtl/core/prf_dp.sv
rtl/core/primitive_root_finder.sv
test/primitive_root_finder_test.sv
